// ===== rtl/tbs_pkg.sv =====
// tbs_pkg: shared types, constants and helpers of the transient burn shaper
`timescale 1ns / 1ps
package tbs_pkg;

  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 24;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int VAL_W      = 40;
  localparam int DIVD_W     = 56;
  localparam int DIVS_W     = 23;
  localparam int QUO_W      = 32;
  localparam int FRAC_W     = 17;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SENSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd5;

  localparam logic [15:0] DECAY_RESET = 16'd64857;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic signed [MUL_B_W-1:0] FAST_ATK = 24'sd4397;
  localparam logic signed [MUL_B_W-1:0] FAST_REL = 24'sd170;
  localparam logic signed [MUL_B_W-1:0] SLOW_ATK = 24'sd114;
  localparam logic signed [MUL_B_W-1:0] SLOW_REL = 24'sd34;
  localparam logic signed [MUL_B_W-1:0] LP_COEF  = 24'sd15095;

  localparam logic signed [VAL_W-1:0] ONE16   = 40'sd65536;
  localparam logic signed [VAL_W-1:0] ONE31   = 40'sd2147483648;
  localparam logic signed [VAL_W-1:0] Q_SAT   = 40'sd196608;
  localparam logic signed [VAL_W-1:0] SOFT_27 = 40'sd1769472;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_USE,
    ST_DIV
  } state_t;

  typedef enum logic [3:0] {
    OP_FAST,
    OP_SLOW,
    OP_TRANS,
    OP_DECAY,
    OP_LP,
    OP_DRIVE,
    OP_BITE,
    OP_XD,
    OP_BH,
    OP_QQ,
    OP_NUM,
    OP_CLIP,
    OP_MKP,
    OP_MIX
  } op_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [CFG_DATA_W-1:0] d);
    logic [PCT_W-1:0] p;
    p = d[PCT_W-1:0];
    return (p > PCT_MAX) ? PCT_MAX : p;
  endfunction

  // round(p * 65536 / 100) as p*655 + floor((36p + 50) / 100)
  function automatic logic [FRAC_W-1:0] frac16(input logic [PCT_W-1:0] p);
    logic [11:0] u;
    logic [25:0] t;
    u = 12'(p) * 12'd36 + 12'd50;
    t = 26'(u) * 26'd10486;
    return FRAC_W'(p) * 17'd655 + FRAC_W'(t[25:20]);
  endfunction

endpackage

// ===== rtl/tbs_if.sv =====
// tbs_if: valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
interface tbs_in_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           block_last;

  modport source (output valid, sample_in, block_last, input ready);
  modport sink (input valid, sample_in, block_last, output ready);
endinterface

interface tbs_out_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           block_end;

  modport source (output valid, sample_out, block_end, input ready);
  modport sink (input valid, sample_out, block_end, output ready);
endinterface

// ===== rtl/tbs_div.sv =====
// tbs_div: restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tbs_div import tbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] dsh_r;
  logic [QUO_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              fits;

  assign fits = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= req.dividend;
        dsh_r  <= DIVD_W'(req.divisor) << (QUO_W - 1);
        quo_r  <= '0;
        cnt_r  <= CNT_W'(QUO_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[QUO_W-2:0], fits};
        dsh_r <= dsh_r >> 1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/transient_burn_shaper.sv =====
// transient_burn_shaper: transient shaper with burn envelope and soft clip
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   sample_in[SAMPLE_WIDTH], block_last
//   out_chan  out  valid/ready   sample_out[SAMPLE_WIDTH], block_end
//   cfg_*     in   cfg_we        cfg_index[3], cfg_data[16]
//
// each word runs 14 products (12 when the soft stage saturates) on one shared
// 34x24 multiplier and two passes of the shared divider (one when saturated),
// then the sequencer returns to idle
// in_chan.ready is high only while the sequencer idles
// a finished word waits in the output register; the next word is taken meanwhile
// synchronous active-low reset clears envelopes, lowpass and output valid, and loads configuration defaults
`timescale 1ns / 1ps
module transient_burn_shaper import tbs_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tbs_in_if.sink                in_chan,
  tbs_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SHIFT = 32 - SAMPLE_WIDTH;
  localparam logic signed [VAL_W-1:0] Y_MAX =
    VAL_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [VAL_W-1:0] Y_MIN = -Y_MAX - 40'sd1;

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [19:0]        sense_fac_r;
  logic [FRAC_W-1:0]  burn_r, edge_r, clip_r, mix_r;
  logic [17:0]        burn3_r;
  logic [15:0]        decay_r;
  logic [FRAC_W-1:0]  cfg_frac;

  logic [31:0]        fast_r, slow_r, be_r, trans_r;
  logic signed [31:0] lp_r, x_r;
  logic               last_r;
  logic [19:0]        drive_r;
  logic [18:0]        bite_r;
  logic signed [37:0] d_r;
  logic signed [18:0] q_r;
  logic [19:0]        q2_r;
  logic signed [32:0] soft_r, shaped_r;
  logic               sign_r;

  logic signed [MUL_A_W-1:0] mul_a_r, mul_a_nxt;
  logic signed [MUL_B_W-1:0] mul_b_r, mul_b_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  p16, p28, p29, p31;

  logic                      out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_r;
  logic                      block_end_r;

  logic signed [VAL_W-1:0] x_w, ax_w, fast_w, slow_w, be_w, trans_w, lp_w, hp_w;
  logic signed [VAL_W-1:0] d_w, d_sum, q_full, soft_w, shaped_w, hard_w;
  logic signed [VAL_W-1:0] be_dec, mix_sum, y_w, y_clamp;
  logic signed [PROD_W-1:0] num_abs;
  logic signed [32:0]       sh_abs, quo_s;
  logic                     in_acc, out_free, bh_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tbs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign p16 = prod_r >>> 16;
  assign p28 = prod_r >>> 28;
  assign p29 = prod_r >>> 29;
  assign p31 = prod_r >>> 31;

  assign x_w      = VAL_W'(x_r);
  assign ax_w     = (x_w < 0) ? -x_w : x_w;
  assign fast_w   = $signed({8'b0, fast_r});
  assign slow_w   = $signed({8'b0, slow_r});
  assign be_w     = $signed({8'b0, be_r});
  assign trans_w  = $signed({8'b0, trans_r});
  assign lp_w     = VAL_W'(lp_r);
  assign hp_w     = x_w - lp_w;
  assign d_w      = VAL_W'(d_r);
  assign d_sum    = d_w + VAL_W'(p16);
  assign q_full   = d_sum >>> 15;
  assign bh_sat   = (q_full >= Q_SAT) || (q_full <= -Q_SAT);
  assign soft_w   = VAL_W'(soft_r);
  assign shaped_w = VAL_W'(shaped_r);
  assign hard_w   = (d_w > ONE31) ? ONE31 : ((d_w < -ONE31) ? -ONE31 : d_w);
  assign be_dec   = VAL_W'(p16);
  assign mix_sum  = x_w + VAL_W'(p16);
  assign y_w      = mix_sum >>> SHIFT;
  assign y_clamp  = (y_w > Y_MAX) ? Y_MAX : ((y_w < Y_MIN) ? Y_MIN : y_w);
  assign num_abs  = (prod_r < 0) ? -prod_r : prod_r;
  assign sh_abs   = (shaped_r < 0) ? -shaped_r : shaped_r;
  assign quo_s    = $signed({1'b0, div_rsp.quotient});
  assign cfg_frac = frac16(sat_pct(cfg_data));

  // operand select
  always_comb begin
    mul_a_nxt = '0;
    mul_b_nxt = '0;
    case (op_r)
      OP_FAST: begin
        mul_a_nxt = MUL_A_W'(ax_w - fast_w);
        mul_b_nxt = (ax_w > fast_w) ? FAST_ATK : FAST_REL;
      end
      OP_SLOW: begin
        mul_a_nxt = MUL_A_W'(ax_w - slow_w);
        mul_b_nxt = (ax_w > slow_w) ? SLOW_ATK : SLOW_REL;
      end
      OP_TRANS: begin
        mul_a_nxt = (fast_w > slow_w) ? MUL_A_W'(fast_w - slow_w) : '0;
        mul_b_nxt = MUL_B_W'($signed({1'b0, sense_fac_r}));
      end
      OP_DECAY: begin
        mul_a_nxt = MUL_A_W'(be_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, decay_r}));
      end
      OP_LP: begin
        mul_a_nxt = MUL_A_W'(x_w - lp_w);
        mul_b_nxt = LP_COEF;
      end
      OP_DRIVE: begin
        mul_a_nxt = MUL_A_W'(be_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, burn_r}));
      end
      OP_BITE: begin
        mul_a_nxt = MUL_A_W'(be_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, edge_r}));
      end
      OP_XD: begin
        mul_a_nxt = MUL_A_W'(x_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, drive_r}));
      end
      OP_BH: begin
        mul_a_nxt = MUL_A_W'(hp_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, bite_r}));
      end
      OP_QQ: begin
        mul_a_nxt = MUL_A_W'(q_r);
        mul_b_nxt = MUL_B_W'(q_r);
      end
      OP_NUM: begin
        mul_a_nxt = MUL_A_W'(q_r);
        mul_b_nxt = MUL_B_W'(SOFT_27 + $signed({20'b0, q2_r}));
      end
      OP_CLIP: begin
        mul_a_nxt = MUL_A_W'(hard_w - soft_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, clip_r}));
      end
      OP_MKP: begin
        mul_a_nxt = MUL_A_W'(be_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, burn3_r}));
      end
      OP_MIX: begin
        mul_a_nxt = MUL_A_W'(shaped_w - x_w);
        mul_b_nxt = MUL_B_W'($signed({1'b0, mix_r}));
      end
      default: begin
        mul_a_nxt = '0;
        mul_b_nxt = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_USE;
      ST_USE: begin
        if (op_r == OP_NUM || op_r == OP_MKP) begin
          state_nxt = ST_DIV;
        end else if (op_r == OP_MIX) begin
          state_nxt = out_free ? ST_IDLE : ST_USE;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_DIV: if (div_rsp.done) state_nxt = ST_LOAD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_chan.ready    = (state_r == ST_IDLE);
    div_req.start    = (state_r == ST_USE) && (op_r == OP_NUM || op_r == OP_MKP);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (op_r == OP_NUM) begin
      div_req.dividend = DIVD_W'(num_abs) << 15;
      div_req.divisor  = DIVS_W'(SOFT_27 + 40'sd9 * $signed({20'b0, q2_r}));
    end else begin
      div_req.dividend = DIVD_W'(sh_abs) << 16;
      div_req.divisor  = DIVS_W'(ONE16 + VAL_W'(p31));
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = sample_out_r;
  assign out_chan.block_end  = block_end_r;

  always_ff @(posedge clk) begin
    mul_a_r <= (state_r == ST_LOAD) ? mul_a_nxt : mul_a_r;
    mul_b_r <= (state_r == ST_LOAD) ? mul_b_nxt : mul_b_r;
    prod_r  <= mul_a_r * mul_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_FAST;
      out_valid_r <= 1'b0;
      sense_fac_r <= 20'd65536;
      burn_r      <= '0;
      burn3_r     <= '0;
      edge_r      <= '0;
      clip_r      <= '0;
      mix_r       <= '0;
      decay_r     <= DECAY_RESET;
      fast_r      <= '0;
      slow_r      <= '0;
      be_r        <= '0;
      lp_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_SENSE: sense_fac_r <= 20'd65536 + 20'(cfg_frac) * 20'd7;
          REG_BURN: begin
            burn_r  <= cfg_frac;
            burn3_r <= 18'(cfg_frac) * 18'd3;
          end
          REG_EDGE:  edge_r  <= cfg_frac;
          REG_CLIP:  clip_r  <= cfg_frac;
          REG_MIX:   mix_r   <= cfg_frac;
          REG_DECAY: decay_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_chan.ready && !(state_r == ST_USE && op_r == OP_MIX)) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        x_r    <= 32'(in_chan.sample_in) <<< SHIFT;
        last_r <= in_chan.block_last;
        op_r   <= OP_FAST;
      end

      if (state_r == ST_USE) begin
        case (op_r)
          OP_FAST:  fast_r <= 32'(fast_w + VAL_W'(p16));
          OP_SLOW:  slow_r <= 32'(slow_w + VAL_W'(p16));
          OP_TRANS: trans_r <= (VAL_W'(p16) > ONE31) ? 32'(ONE31) : 32'(p16);
          OP_DECAY: be_r <= (trans_w > be_dec) ? trans_r : 32'(be_dec);
          OP_LP:    lp_r <= 32'(lp_w + VAL_W'(p16));
          OP_DRIVE: drive_r <= 20'(ONE16 + VAL_W'(p28));
          OP_BITE:  bite_r <= 19'(p29);
          OP_XD:    d_r <= 38'(p16);
          OP_BH: begin
            d_r <= 38'(d_sum);
            q_r <= 19'(q_full);
            if (q_full >= Q_SAT) begin
              soft_r <= 33'(ONE31);
            end else if (q_full <= -Q_SAT) begin
              soft_r <= 33'(-ONE31);
            end
          end
          OP_QQ:    q2_r <= 20'(p16);
          OP_NUM:   sign_r <= (prod_r < 0);
          OP_CLIP:  shaped_r <= 33'(soft_w + VAL_W'(p16));
          OP_MKP:   sign_r <= (shaped_r < 0);
          OP_MIX: begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              sample_out_r <= SAMPLE_WIDTH'(y_clamp);
              block_end_r  <= last_r;
            end
          end
          default: ;
        endcase
        if (op_r == OP_BH && bh_sat) begin
          op_r <= OP_CLIP;
        end else if (op_r != OP_NUM && op_r != OP_MKP && op_r != OP_MIX) begin
          op_r <= op_t'(op_r + 4'd1);
        end
      end

      if (state_r == ST_DIV && div_rsp.done) begin
        if (op_r == OP_NUM) begin
          soft_r <= sign_r ? -quo_s : quo_s;
        end else begin
          shaped_r <= sign_r ? -quo_s : quo_s;
        end
        op_r <= op_t'(op_r + 4'd1);
      end
    end
  end

endmodule

// ===== rtl/tbs_checker.sv =====
// tbs_checker: port-level assertions of the transient burn shaper and its bind
`timescale 1ns / 1ps
module tbs_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample,
  input logic                    out_end
);

  // sequencer leaves idle once a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready right after a word was taken");

  // a result only appears at the end of a busy stretch
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the sequencer was idle");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_sample) && $stable(out_end))
    else $error("stalled result changed or dropped");

endmodule

bind transient_burn_shaper tbs_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_sample(out_chan.sample_out),
  .out_end   (out_chan.block_end)
);

// ===== dv/transient_burn_shaper_tb.sv =====
// transient_burn_shaper_tb: self-checking testbench with a bit-exact predictor of the shaper
`timescale 1ns / 1ps
module transient_burn_shaper_tb import tbs_pkg::*;;

  localparam int SW         = 24;
  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE     = 200;
  localparam longint UNITY  = 64'sd2147483648;

  typedef struct {
    logic [SW-1:0] smp;
    logic          last;
  } shaper_word_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tbs_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  tbs_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  transient_burn_shaper #(.SAMPLE_WIDTH(SW)) uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_ch), .out_chan(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and state
  longint sense_pct, burn_pct, edge_pct, clip_pct, mix_pct, decay_q16;
  longint fast_env, slow_env, burn_env, lp_acc;

  shaper_word_t shaped_q[$];
  int  err_count;
  int  idle_cycles;
  bit  steady;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic longint pct_frac(input longint p);
    return (p * 65536 + 50) / 100;
  endfunction

  function automatic longint env_follow(input longint env, input longint a,
                                        input longint atk, input longint rel);
    longint c;
    c = (a > env) ? atk : rel;
    return env + ((c * (a - env)) >>> 16);
  endfunction

  function automatic longint tanh_approx(input longint d);
    longint q, q2, num, den;
    q = d >>> 15;
    if (q >= 3 * 65536) return UNITY;
    if (q <= -3 * 65536) return -UNITY;
    q2 = (q * q) >>> 16;
    num = q * (27 * 65536 + q2);
    den = 27 * 65536 + 9 * q2;
    return (num * 32768) / den;
  endfunction

  function automatic logic [SW-1:0] shape_sample(input logic signed [SW-1:0] s);
    longint x, ax, sense, burn, edg, clip, mix;
    longint detect, trans, hp, drive, bite, d, sat_v, hard, shaped, makeup, y;
    x = longint'(s) * 256;
    ax = (x < 0) ? -x : x;
    sense = pct_frac(sense_pct);
    burn = pct_frac(burn_pct);
    edg = pct_frac(edge_pct);
    clip = pct_frac(clip_pct);
    mix = pct_frac(mix_pct);
    fast_env = env_follow(fast_env, ax, 4397, 170);
    slow_env = env_follow(slow_env, ax, 114, 34);
    detect = fast_env - slow_env;
    if (detect < 0) detect = 0;
    trans = (detect * (65536 + 7 * sense)) >>> 16;
    if (trans > UNITY) trans = UNITY;
    burn_env = (burn_env * decay_q16) >>> 16;
    if (trans > burn_env) burn_env = trans;
    lp_acc = lp_acc + ((15095 * (x - lp_acc)) >>> 16);
    hp = x - lp_acc;
    drive = 65536 + ((burn * 8 * burn_env) >>> 31);
    bite = (edg * 4 * burn_env) >>> 31;
    d = ((x * drive) >>> 16) + ((bite * hp) >>> 16);
    sat_v = tanh_approx(d);
    hard = (d > UNITY) ? UNITY : ((d < -UNITY) ? -UNITY : d);
    shaped = sat_v + ((clip * (hard - sat_v)) >>> 16);
    makeup = 65536 + ((burn * 3 * burn_env) >>> 31);
    shaped = (shaped * 65536) / makeup;
    y = (x + ((mix * (shaped - x)) >>> 16)) >>> 8;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return y[SW-1:0];
  endfunction

  task automatic send_word(input logic [SW-1:0] smp, input logic last);
    int gap;
    shaper_word_t w;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= smp;
    in_ch.block_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    w.smp = shape_sample(smp);
    w.last = last;
    shaped_q.push_back(w);
    @(negedge clk);
  endtask

  // lower valid, wait for all results and let the block settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (shaped_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    longint p;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    p = longint'(data[6:0]);
    if (p > 100) p = 100;
    case (idx)
      REG_SENSE: sense_pct = p;
      REG_BURN:  burn_pct = p;
      REG_EDGE:  edge_pct = p;
      REG_CLIP:  clip_pct = p;
      REG_MIX:   mix_pct = p;
      REG_DECAY: decay_q16 = longint'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_all(input logic [15:0] s, input logic [15:0] b, input logic [15:0] e,
                         input logic [15:0] c, input logic [15:0] m, input logic [15:0] dc);
    cfg_write(REG_SENSE, s);
    cfg_write(REG_BURN, b);
    cfg_write(REG_EDGE, e);
    cfg_write(REG_CLIP, c);
    cfg_write(REG_MIX, m);
    cfg_write(REG_DECAY, dc);
  endtask

  // result side: random stalls, compare with oldest prediction
  initial begin
    int gap;
    shaper_word_t w;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (shaped_q.size() == 0) begin
        report_mismatch("result word with no prediction");
      end else begin
        w = shaped_q.pop_front();
        if (out_ch.sample_out !== w.smp)
          report_mismatch($sformatf("sample_out %h, predicted %h", out_ch.sample_out, w.smp));
        if (out_ch.block_end !== w.last)
          report_mismatch($sformatf("block_end %b, predicted %b", out_ch.block_end, w.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [SW-1:0] rand_sample(input bit loud);
    int sel;
    logic [SW-1:0] v;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 24'h7fffff;
    if (sel == 1) return 24'h800000;
    if (sel <= 4) return SW'($urandom());
    v = SW'(loud ? $urandom_range(0, 24'h7fffff) : $urandom_range(0, 4095));
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  task automatic test_reset_defaults;
    send_word(24'h000000, 1'b0);
    send_word(24'h7fffff, 1'b1);
    send_word(24'h800000, 1'b0);
    send_word(24'hffffff, 1'b1);
    send_word(24'h000001, 1'b0);
    drain();
  endtask

  task automatic test_directed_extremes;
    // percents above range saturate, unknown indexes are ignored
    cfg_all(16'h007f, 16'hff7f, 16'd100, 16'd0, 16'd100, 16'd65535);
    cfg_write(3'd6, 16'hffff);
    cfg_write(3'd7, 16'h0000);
    repeat (3) send_word(24'h000000, 1'b0);
    repeat (3) send_word(24'h7fffff, 1'b0);
    repeat (2) send_word(24'h800000, 1'b1);
    send_word(24'h000000, 1'b0);
    drain();
    cfg_write(REG_CLIP, 16'd100);
    // zero decay: burn envelope tracks the transient
    cfg_write(REG_DECAY, 16'd0);
    repeat (2) send_word(24'h000000, 1'b0);
    repeat (3) send_word(24'h7fffff, 1'b0);
    send_word(24'h400000, 1'b1);
    send_word(24'hc00000, 1'b0);
    send_word(24'h000000, 1'b1);
    drain();
  endtask

  task automatic test_random_phases;
    int n, run;
    bit loud;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: cfg_all(16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd65535);
        2: cfg_all(16'd100, 16'd100, 16'd100, 16'd0, 16'd100, 16'd0);
        default: cfg_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()), 16'($urandom_range(50, 127)),
                         16'($urandom()));
      endcase
      steady = (ph == 4);
      n = 0;
      while (n < 150) begin
        // bursts of loud words after quiet stretches build transients
        loud = ($urandom_range(0, 2) == 0);
        run = $urandom_range(1, 20);
        for (int k = 0; k < run && n < 150; k++) begin
          send_word(rand_sample(loud), 1'($urandom_range(0, 1)));
          n++;
          if (ph == 5 && n == 75) begin
            in_ch.valid <= 1'b0;
            while (shaped_q.size() != 0) @(negedge clk);
          end
        end
      end
      steady = 1'b0;
      drain();
    end
  endtask

  initial begin
    err_count = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.block_last = 1'b0;
    sense_pct = 0; burn_pct = 0; edge_pct = 0; clip_pct = 0; mix_pct = 0;
    decay_q16 = 64857;
    fast_env = 0; slow_env = 0; burn_env = 0; lp_acc = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(negedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_phases();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tbs_pkg.sv
rtl/tbs_if.sv
rtl/tbs_div.sv
rtl/transient_burn_shaper.sv
rtl/tbs_checker.sv
dv/transient_burn_shaper_tb.sv
